@@ rtl/core/grid_path_count_through_color_core_assert.svh @@
// assertion macros for the grid path counter core
// used by the top level only, no other dependencies
`ifndef GRID_PATH_COUNT_THROUGH_COLOR_CORE_ASSERT_SVH
`define GRID_PATH_COUNT_THROUGH_COLOR_CORE_ASSERT_SVH
`ifndef SYNTH
`define GPC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("gpc assertion failed");
`define GPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gpc assertion failed");
`else
`define GPC_ASSERT(lbl, prop)
`define GPC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/core/gpc_pkg.sv @@
// shared types, constants and modular add for the grid path counter
// no dependencies
package gpc_pkg;

  localparam int VAL_W      = 30;
  localparam int ROWS_W     = 16;
  localparam int COLS_W     = 11;
  localparam int COLOR_W    = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [VAL_W-1:0] PRIME = 30'd998244353;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS    = 2'd0,
    REG_GRID_COLS    = 2'd1,
    REG_TARGET_COLOR = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic first_row;
    logic first_col;
    logic hit;
  } cell_ctrl_t;

  function automatic logic [VAL_W-1:0] mod_add(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    logic [VAL_W:0] sum;
    logic [VAL_W:0] diff;
    sum  = {1'b0, a} + {1'b0, b};
    diff = sum - {1'b0, PRIME};
    return (sum >= {1'b0, PRIME}) ? diff[VAL_W-1:0] : sum[VAL_W-1:0];
  endfunction

endpackage

@@ rtl/core/grid_path_count_through_color_core.sv @@
// top level of the grid path counter: position tracking, line store, output register
// depends on gpc_pkg, gpc_ram, gpc_update and the assertion macro header
//
// channel | direction | handshake             | payload
// cfg     | in        | cfg_valid_i/ready_o   | cfg_index_i, cfg_data_i
// in      | in        | in_valid_i/stall_o    | cell_color_i
// out     | out       | out_valid_o/stall_i   | paths_avoiding_o, paths_through_o, grid_done_o
//
// one cell per cycle unless stalled; results pass the update stage and output register
// the line store is read when a cell is taken and written back as it leaves the update stage,
// a one-column grid forwards the written counts to the next read
// reset clears position, left counts and valid flags; the line store is not cleared
// a stalled output holds one result while one more cell may still be taken
`include "grid_path_count_through_color_core_assert.svh"
module grid_path_count_through_color_core #(
  parameter int MAX_COLS   = 1024,
  parameter int COLOR_BITS = 20
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [gpc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [gpc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [gpc_pkg::COLOR_W-1:0]      cell_color_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [gpc_pkg::VAL_W-1:0]        paths_avoiding_o,
  output logic [gpc_pkg::VAL_W-1:0]        paths_through_o,
  output logic                             grid_done_o
);

  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CMP_W = (COLOR_BITS < gpc_pkg::COLOR_W) ? COLOR_BITS : gpc_pkg::COLOR_W;
  localparam int VW    = gpc_pkg::VAL_W;
  localparam logic [16:0] MAX_COLS_L = 17'(MAX_COLS);

  // configuration registers
  logic [gpc_pkg::ROWS_W-1:0]  rows_q;
  logic [gpc_pkg::COLS_W-1:0]  cols_q;
  logic [gpc_pkg::COLOR_W-1:0] target_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q   <= gpc_pkg::ROWS_W'(1);
      cols_q   <= gpc_pkg::COLS_W'(1);
      target_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (gpc_pkg::cfg_reg_e'(cfg_index_i))
        gpc_pkg::REG_GRID_ROWS:    rows_q   <= cfg_data_i[gpc_pkg::ROWS_W-1:0];
        gpc_pkg::REG_GRID_COLS:    cols_q   <= cfg_data_i[gpc_pkg::COLS_W-1:0];
        gpc_pkg::REG_TARGET_COLOR: target_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective grid size
  logic [16:0] rows_eff, cols_ext, cols_eff;
  assign rows_eff = (rows_q == '0) ? 17'd1 : 17'(rows_q);
  assign cols_ext = 17'(cols_q);
  assign cols_eff = (cols_ext == '0) ? 17'd1 :
                    (cols_ext > MAX_COLS_L) ? MAX_COLS_L : cols_ext;

  // position of the next cell
  logic [gpc_pkg::ROWS_W-1:0] row_q, row_d;
  logic [COL_W-1:0]           col_q, col_d;
  logic                       row_end, grid_end, in_acc;

  assign row_end  = (17'(col_q) + 17'd1) >= cols_eff;
  assign grid_end = row_end && ((17'(row_q) + 17'd1) >= rows_eff);
  assign in_acc   = in_valid_i && !in_stall_o;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (in_acc) begin
      priority if (grid_end) begin
        row_d = '0;
        col_d = '0;
      end else if (row_end) begin
        row_d = row_q + gpc_pkg::ROWS_W'(1);
        col_d = '0;
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // update stage: line store read data arrives here
  logic                  s1_valid_q, s1_done_q, s1_fwd_q, s1_adv;
  gpc_pkg::cell_ctrl_t   s1_ctrl_q, s1_ctrl_d;
  logic [COL_W-1:0]      s1_col_q;
  logic [2*VW-1:0]       fwd_data_q, ram_rdata, up_data, wdata;
  logic [VW-1:0]         left_avoid_q, left_through_q;
  logic [VW-1:0]         upd_avoid, upd_through;
  logic                  out_valid_q, out_done_q;
  logic [VW-1:0]         out_avoid_q, out_through_q;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;

  always_comb begin
    s1_ctrl_d.first_row = (row_q == '0);
    s1_ctrl_d.first_col = (col_q == '0);
    s1_ctrl_d.hit       = (cell_color_i[CMP_W-1:0] == target_q[CMP_W-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_ctrl_q  <= s1_ctrl_d;
      s1_col_q   <= col_q;
      s1_done_q  <= grid_end;
      // same entry written this cycle: the ram read returns the old value
      s1_fwd_q   <= s1_adv && (s1_col_q == col_q);
      fwd_data_q <= wdata;
    end
  end

  gpc_ram #(
    .WIDTH (2*VW),
    .DEPTH (MAX_COLS)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (wdata),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  assign up_data = s1_fwd_q ? fwd_data_q : ram_rdata;

  gpc_update u_update (
    .ctrl_i         (s1_ctrl_q),
    .up_avoid_i     (up_data[2*VW-1:VW]),
    .up_through_i   (up_data[VW-1:0]),
    .left_avoid_i   (left_avoid_q),
    .left_through_i (left_through_q),
    .avoid_o        (upd_avoid),
    .through_o      (upd_through)
  );

  assign wdata = {upd_avoid, upd_through};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_avoid_q   <= '0;
      left_through_q <= '0;
    end else if (s1_adv) begin
      left_avoid_q   <= upd_avoid;
      left_through_q <= upd_through;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_avoid_q   <= upd_avoid;
      out_through_q <= upd_through;
      out_done_q    <= s1_done_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign paths_avoiding_o = out_avoid_q;
  assign paths_through_o  = out_through_q;
  assign grid_done_o      = out_done_q;

  `GPC_ASSERT(a_counts_reduced, out_valid_o |-> (paths_avoiding_o < gpc_pkg::PRIME && paths_through_o < gpc_pkg::PRIME))
  `GPC_ASSERT_NEXT(a_hit_clears_avoid, s1_adv && s1_ctrl_q.hit, paths_avoiding_o == '0)
  `GPC_ASSERT_NEXT(a_grid_wraps, in_acc && grid_end, row_q == '0 && col_q == '0)
  `GPC_ASSERT(a_fwd_first_col, (s1_valid_q && s1_fwd_q) |-> (s1_col_q == '0))

endmodule

@@ rtl/core/gpc_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module gpc_ram #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/gpc_update.sv @@
// per-cell count update: above plus left, then fold at a target cell
// depends on gpc_pkg
module gpc_update (
  input  gpc_pkg::cell_ctrl_t            ctrl_i,
  input  logic [gpc_pkg::VAL_W-1:0]      up_avoid_i,
  input  logic [gpc_pkg::VAL_W-1:0]      up_through_i,
  input  logic [gpc_pkg::VAL_W-1:0]      left_avoid_i,
  input  logic [gpc_pkg::VAL_W-1:0]      left_through_i,
  output logic [gpc_pkg::VAL_W-1:0]      avoid_o,
  output logic [gpc_pkg::VAL_W-1:0]      through_o
);

  logic [gpc_pkg::VAL_W-1:0] ua, ut, la, lt, sa, st;

  always_comb begin
    ua = ctrl_i.first_row ? '0 : up_avoid_i;
    ut = ctrl_i.first_row ? '0 : up_through_i;
    la = ctrl_i.first_col ? '0 : left_avoid_i;
    lt = ctrl_i.first_col ? '0 : left_through_i;
    // top-left cell seeds a single avoiding path
    if (ctrl_i.first_row && ctrl_i.first_col) begin
      sa = gpc_pkg::VAL_W'(1);
      st = '0;
    end else begin
      sa = gpc_pkg::mod_add(ua, la);
      st = gpc_pkg::mod_add(ut, lt);
    end
    if (ctrl_i.hit) begin
      avoid_o   = '0;
      through_o = gpc_pkg::mod_add(st, sa);
    end else begin
      avoid_o   = sa;
      through_o = st;
    end
  end

endmodule
